// ===== hw/rtl/polygon_plane_clipper_top_macros.svh =====
// Assertion macros used by the polygon plane clipper top level.
`ifndef POLYGON_PLANE_CLIPPER_TOP_MACROS_SVH
`define POLYGON_PLANE_CLIPPER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks that the consequent holds in the same cycle as the antecedent.
`define PCL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define PCL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PCL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define PCL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/pcl_pkg.sv =====
// Types and constants shared by the polygon plane clipper modules.
package pcl_pkg;

   localparam int MAX_VERTS_DEF = 16;
   localparam int COORD_W = 32;
   localparam int DOT_W = 52;
   localparam int FRAC_W = 16;
   localparam int TOL_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int MIN_POLY = 3;
   localparam logic signed [DOT_W-1:0] ONE_Q = DOT_W'(65536);

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NORMAL_X = 3'd0,
      CSR_NORMAL_Y = 3'd1,
      CSR_NORMAL_Z = 3'd2,
      CSR_ORIGIN_X = 3'd3,
      CSR_ORIGIN_Y = 3'd4,
      CSR_ORIGIN_Z = 3'd5,
      CSR_DUP_TOL  = 3'd6
   } csr_idx_type;

   // Three coordinates, axis 0 is x.
   typedef logic [2:0][COORD_W-1:0] vec3_type;

   typedef struct packed {
      vec3_type            normal;
      vec3_type            origin;
      logic [TOL_W-1:0]    dup_tol;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] vert_x;
      logic signed [COORD_W-1:0] vert_y;
      logic signed [COORD_W-1:0] vert_z;
      logic                      last_in;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic                      poly_empty;
      logic                      last_out;
   } rsp_type;

endpackage

// ===== hw/rtl/polygon_plane_clipper_top.sv =====
// Top level of the polygon plane clipper: registers, vertex stores and sequencer.
`include "polygon_plane_clipper_top_macros.svh"
// Vertices are taken one per cycle while busy is low; a transfer without
// last_in only writes the input store. The transfer flagged last_in closes the
// polygon and busy stays high until its last result is out. The clip first
// reads vertex 0 to find its side of the plane, then walks one edge per
// vertex plus the closing edge. Each dot product runs its three axes through
// one shared multiplier. On a crossing, an edge that runs parallel to the
// plane adds no crossing point; otherwise the crossing point clamps to an end
// of the edge, or the 16-step divider and the interpolation run. Vertices
// copied after a firm second crossing pass through a read state and a write
// state each. The results follow the walk through the done and emit states,
// one per cycle, with rsp_valid high for one cycle each, and cannot be held
// off. Configuration writes are accepted while busy is low.
module polygon_plane_clipper_top #(
   parameter int MAX_VERTS = pcl_pkg::MAX_VERTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  pcl_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   output pcl_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pcl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pcl_pkg::COORD_W-1:0]         csr_wdata
);
   import pcl_pkg::*;

   localparam int AW  = $clog2(MAX_VERTS);
   localparam int OD  = 2 * MAX_VERTS + 2;
   localparam int OAW = $clog2(OD);

   cfg_type        cfg_ff;
   logic           in_we, out_we;
   logic [AW-1:0]  in_waddr, in_raddr;
   logic [OAW-1:0] out_waddr, out_raddr;
   vec3_type       in_wdata, in_rdata, out_wdata, out_rdata;

   assign csr_ready = !busy;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.normal  <= {COORD_W'(65536), COORD_W'(0), COORD_W'(0)};
         cfg_ff.origin  <= '0;
         cfg_ff.dup_tol <= TOL_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_NORMAL_X: cfg_ff.normal[0] <= csr_wdata;
            CSR_NORMAL_Y: cfg_ff.normal[1] <= csr_wdata;
            CSR_NORMAL_Z: cfg_ff.normal[2] <= csr_wdata;
            CSR_ORIGIN_X: cfg_ff.origin[0] <= csr_wdata;
            CSR_ORIGIN_Y: cfg_ff.origin[1] <= csr_wdata;
            CSR_ORIGIN_Z: cfg_ff.origin[2] <= csr_wdata;
            CSR_DUP_TOL:  cfg_ff.dup_tol   <= csr_wdata[TOL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   pcl_ram #(.DEPTH(MAX_VERTS)) u_in_store (
      .clock      (clock),
      .wr_en      (in_we),
      .wr_addr    (in_waddr),
      .wr_data    (in_wdata),
      .rd_addr    (in_raddr),
      .rd_data_ff (in_rdata)
   );

   pcl_ram #(.DEPTH(OD)) u_out_store (
      .clock      (clock),
      .wr_en      (out_we),
      .wr_addr    (out_waddr),
      .wr_data    (out_wdata),
      .rd_addr    (out_raddr),
      .rd_data_ff (out_rdata)
   );

   pcl_core #(.MAX_VERTS(MAX_VERTS)) u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .in_we     (in_we),
      .in_waddr  (in_waddr),
      .in_wdata  (in_wdata),
      .in_raddr  (in_raddr),
      .in_rdata  (in_rdata),
      .out_we    (out_we),
      .out_waddr (out_waddr),
      .out_wdata (out_wdata),
      .out_raddr (out_raddr),
      .out_rdata (out_rdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Results only appear while a polygon is in flight.
   `PCL_ASSERT_NOW(a_rsp_busy, clock, reset, rsp_valid, busy, "result outside a polygon")
   // Nothing follows the final result of a polygon.
   `PCL_ASSERT_NEXT(a_last_gap, clock, reset, rsp_valid && rsp_data.last_out, !rsp_valid,
                    "result after final result")
   // An empty polygon is reported as its only result.
   `PCL_ASSERT_NOW(a_empty_last, clock, reset, rsp_valid && rsp_data.poly_empty,
                   rsp_data.last_out, "empty result not final")
   // A closing vertex starts the clip.
   `PCL_ASSERT_NEXT(a_close_busy, clock, reset, start && !busy && req_data.last_in, busy,
                    "closing vertex did not start the clip")

endmodule

// ===== hw/rtl/pcl_ram.sv =====
// Single write port, single read port vertex memory with registered read data.
module pcl_ram #(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  pcl_pkg::vec3_type          wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output pcl_pkg::vec3_type          rd_data_ff
);
   import pcl_pkg::*;

   vec3_type mem [DEPTH];

   // Write and read in the same clocked block; read data is registered and appears in the cycle after the address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ===== hw/rtl/pcl_div.sv =====
// Restoring divider producing one quotient bit per cycle for a proper fraction.
module pcl_div #(
   parameter int DW = 52,
   parameter int QW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic [QW-1:0] quot_ff,
   output logic          done_ff
);
   import pcl_pkg::*;

   localparam int NW = $clog2(QW + 1);

   logic [DW:0]   rem_ff;
   logic [DW-1:0] dsr_ff;
   logic [NW-1:0] cnt_ff;
   logic          run_ff;
   logic [DW:0]   rem_sh;
   logic          ge;

   // One trial subtraction per cycle.
   assign rem_sh = {rem_ff[DW-1:0], 1'b0};
   assign ge     = rem_sh >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         // Done pulses for one cycle after the final quotient bit.
         done_ff <= !start && run_ff && (cnt_ff == NW'(QW - 1));
         if (start) begin
            run_ff  <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= {1'b0, dividend};
            dsr_ff  <= divisor;
            quot_ff <= '0;
         end else if (run_ff) begin
            rem_ff  <= ge ? rem_sh - {1'b0, dsr_ff} : rem_sh;
            quot_ff <= {quot_ff[QW-2:0], ge};
            cnt_ff  <= cnt_ff + NW'(1);
            if (cnt_ff == NW'(QW - 1)) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

endmodule

// ===== hw/rtl/pcl_core.sv =====
// Clipping sequencer: loads vertices, walks the edges and streams the result.
module pcl_core #(
   parameter int MAX_VERTS = pcl_pkg::MAX_VERTS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  pcl_pkg::req_type                        req_data,
   input  pcl_pkg::cfg_type                        cfg,
   output logic                                    in_we,
   output logic [$clog2(MAX_VERTS)-1:0]            in_waddr,
   output pcl_pkg::vec3_type                       in_wdata,
   output logic [$clog2(MAX_VERTS)-1:0]            in_raddr,
   input  pcl_pkg::vec3_type                       in_rdata,
   output logic                                    out_we,
   output logic [$clog2(2*MAX_VERTS+2)-1:0]        out_waddr,
   output pcl_pkg::vec3_type                       out_wdata,
   output logic [$clog2(2*MAX_VERTS+2)-1:0]        out_raddr,
   input  pcl_pkg::vec3_type                       out_rdata,
   output logic                                    rsp_valid,
   output pcl_pkg::rsp_type                        rsp_data
);
   import pcl_pkg::*;

   localparam int AW  = $clog2(MAX_VERTS);
   localparam int CW  = $clog2(MAX_VERTS + 1);
   localparam int OD  = 2 * MAX_VERTS + 2;
   localparam int OAW = $clog2(OD);
   localparam int OCW = $clog2(OD + 1);
   localparam int PW  = 2 * (COORD_W + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_RD, S_LOAD, S_DIST, S_DEN, S_NUM, S_SEL, S_DIV, S_INTERP,
      S_PUSH, S_CNT, S_NEXT, S_CRD, S_CWR, S_DONE, S_EMIT, S_DRAIN
   } state_type;

   state_type                state_ff;
   logic [CW-1:0]            in_count_ff, n_ff, idx_ff;
   logic                     init_ff, pin_ff, cin_ff, cnt_ff;
   vec3_type                 prev_ff, cur_ff, point_ff, first_ff, last_ff;
   logic [1:0]               step_ff;
   logic signed [PW-1:0]     prod_ff;
   logic signed [DOT_W-1:0]  acc_ff, den_ff, num_ff;
   logic [OCW-1:0]           out_count_ff, emit_ff;
   logic                     rsp_v_ff, rsp_last_ff, rsp_empty_ff;

   logic [CW-1:0]            cnt_new;
   logic                     wrap;
   logic [1:0]               kk, kp;
   vec3_type                 da, db;
   logic signed [COORD_W:0]  diff, op_a;
   logic signed [PW-1:0]     term;
   logic signed [DOT_W-1:0]  acc_fin;
   logic                     cin_new;
   logic [DOT_W-1:0]         num_mag, den_mag;
   logic                     take_prev, take_cur, div_go, div_done;
   logic [FRAC_W-1:0]        quot;
   vec3_type                 push_v;
   logic                     checked, push_ok;

   // True when two vertices differ by more than the tolerance on some axis.
   function automatic logic far_from(vec3_type a, vec3_type b, logic [TOL_W-1:0] tol);
      logic signed [COORD_W:0] d;
      logic [COORD_W:0]        m;
      logic                    r;
      r = 1'b0;
      for (int k = 0; k < 3; k++) begin
         d = $signed({a[k][COORD_W-1], a[k]}) - $signed({b[k][COORD_W-1], b[k]});
         m = d[COORD_W] ? -d : d;
         if (m > {{(COORD_W + 1 - TOL_W){1'b0}}, tol}) begin
            r = 1'b1;
         end
      end
      return r;
   endfunction

   assign busy    = state_ff != S_IDLE;
   assign cnt_new = in_count_ff + ((in_count_ff < CW'(MAX_VERTS)) ? CW'(1) : CW'(0));
   assign wrap    = idx_ff == n_ff;

   // Input store writes happen at the transfer of each vertex while the store has room.
   assign in_we    = start && !busy && (in_count_ff < CW'(MAX_VERTS));
   assign in_waddr = in_count_ff[AW-1:0];
   assign in_wdata = {req_data.vert_z, req_data.vert_y, req_data.vert_x};
   assign in_raddr = (state_ff == S_RD && wrap) ? '0 : idx_ff[AW-1:0];

   // Shared multiplier: operands picked by state and axis step.
   assign kk = (step_ff == 2'd3) ? 2'd0 : step_ff;
   assign kp = step_ff - 2'd1;
   always_comb begin
      unique case (state_ff)
         S_DIST: begin
            da = cur_ff;
            db = cfg.origin;
         end
         S_NUM: begin
            da = cfg.origin;
            db = prev_ff;
         end
         default: begin
            da = cur_ff;
            db = prev_ff;
         end
      endcase
   end
   assign diff = $signed({da[kk][COORD_W-1], da[kk]}) - $signed({db[kk][COORD_W-1], db[kk]});
   assign op_a = (state_ff == S_INTERP) ? $signed({{(COORD_W + 1 - FRAC_W){1'b0}}, quot})
                                        : $signed({cfg.normal[kk][COORD_W-1], cfg.normal[kk]});
   assign term    = prod_ff >>> FRAC_W;
   assign acc_fin = acc_ff + term[DOT_W-1:0];
   assign cin_new = !acc_fin[DOT_W-1] && (acc_fin != '0);

   // Crossing parameter selection ahead of the division.
   assign num_mag   = num_ff[DOT_W-1] ? -num_ff : num_ff;
   assign den_mag   = den_ff[DOT_W-1] ? -den_ff : den_ff;
   assign take_prev = (num_ff == '0) || (num_ff[DOT_W-1] != den_ff[DOT_W-1]);
   assign take_cur  = num_mag >= den_mag;
   assign div_go    = (state_ff == S_SEL) && !take_prev && !take_cur;

   pcl_div #(.DW(DOT_W), .QW(FRAC_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (num_mag),
      .divisor  (den_mag),
      .quot_ff  (quot),
      .done_ff  (div_done)
   );

   // Output store pushes, with the duplicate check on kept and inserted vertices.
   always_comb begin
      unique case (state_ff)
         S_LOAD:  push_v = prev_ff;
         S_CWR:   push_v = in_rdata;
         default: push_v = point_ff;
      endcase
   end
   assign checked = (state_ff == S_LOAD && !init_ff && pin_ff) || (state_ff == S_PUSH);
   assign push_ok = (out_count_ff == '0) ||
                    (far_from(push_v, last_ff, cfg.dup_tol) &&
                     (!wrap || far_from(push_v, first_ff, cfg.dup_tol)));
   assign out_we    = (out_count_ff < OCW'(OD)) && ((checked && push_ok) || state_ff == S_CWR);
   assign out_waddr = out_count_ff[OAW-1:0];
   assign out_wdata = push_v;
   assign out_raddr = emit_ff[OAW-1:0];

   // Result port driven from the registered read data.
   assign rsp_valid           = rsp_v_ff;
   assign rsp_data.out_x      = rsp_empty_ff ? '0 : out_rdata[0];
   assign rsp_data.out_y      = rsp_empty_ff ? '0 : out_rdata[1];
   assign rsp_data.out_z      = rsp_empty_ff ? '0 : out_rdata[2];
   assign rsp_data.poly_empty = rsp_empty_ff;
   assign rsp_data.last_out   = rsp_last_ff;

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         in_count_ff <= '0;
         rsp_v_ff    <= 1'b0;
      end else begin
         // A result is presented after each emit cycle, or once for an empty polygon.
         rsp_v_ff <= (state_ff == S_EMIT) ||
                     (state_ff == S_DONE && out_count_ff < OCW'(MIN_POLY));
         if (out_we) begin
            out_count_ff <= out_count_ff + OCW'(1);
            last_ff      <= push_v;
            if (out_count_ff == '0) begin
               first_ff <= push_v;
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  if (req_data.last_in) begin
                     n_ff         <= cnt_new;
                     in_count_ff  <= '0;
                     idx_ff       <= '0;
                     init_ff      <= 1'b1;
                     cnt_ff       <= 1'b0;
                     out_count_ff <= '0;
                     state_ff     <= S_RD;
                  end else begin
                     in_count_ff <= cnt_new;
                  end
               end
            end
            S_RD: begin
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               cur_ff   <= in_rdata;
               step_ff  <= '0;
               acc_ff   <= '0;
               state_ff <= S_DIST;
            end
            S_DIST, S_DEN, S_NUM, S_INTERP: begin
               prod_ff <= op_a * diff;
               step_ff <= step_ff + 2'd1;
               if (step_ff == 2'd3) begin
                  acc_ff <= '0;
               end else if (step_ff != 2'd0) begin
                  acc_ff <= acc_fin;
               end
               if (step_ff != 2'd0 && state_ff == S_INTERP) begin
                  point_ff[kp] <= prev_ff[kp] + term[COORD_W-1:0];
               end
               if (step_ff == 2'd3) begin
                  unique case (state_ff)
                     S_DIST: begin
                        cin_ff <= cin_new;
                        if (init_ff) begin
                           prev_ff  <= cur_ff;
                           pin_ff   <= cin_new;
                           init_ff  <= 1'b0;
                           state_ff <= S_RD;
                        end else if (pin_ff != cin_new) begin
                           state_ff <= S_DEN;
                        end else begin
                           state_ff <= S_NEXT;
                        end
                     end
                     S_DEN: begin
                        den_ff   <= acc_fin;
                        state_ff <= (acc_fin != '0) ? S_NUM : S_CNT;
                     end
                     S_NUM: begin
                        num_ff   <= acc_fin;
                        state_ff <= S_SEL;
                     end
                     default: begin
                        state_ff <= S_PUSH;
                     end
                  endcase
               end
            end
            S_SEL: begin
               priority if (take_prev) begin
                  point_ff <= prev_ff;
                  state_ff <= S_PUSH;
               end else if (take_cur) begin
                  point_ff <= cur_ff;
                  state_ff <= S_PUSH;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_INTERP;
               end
            end
            S_PUSH: begin
               state_ff <= S_CNT;
            end
            S_CNT: begin
               if (cnt_ff) begin
                  priority if (den_ff > -ONE_Q && den_ff < ONE_Q) begin
                     cnt_ff   <= 1'b0;
                     state_ff <= S_NEXT;
                  end else if (cin_ff) begin
                     state_ff <= S_CRD;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end else begin
                  cnt_ff   <= 1'b1;
                  state_ff <= S_NEXT;
               end
            end
            S_NEXT: begin
               prev_ff <= cur_ff;
               pin_ff  <= cin_ff;
               if (wrap) begin
                  state_ff <= S_DONE;
               end else begin
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= S_RD;
               end
            end
            S_CRD: begin
               if (idx_ff >= n_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= S_CWR;
               end
            end
            S_CWR: begin
               state_ff <= S_CRD;
            end
            S_DONE: begin
               emit_ff <= '0;
               if (out_count_ff < OCW'(MIN_POLY)) begin
                  rsp_empty_ff <= 1'b1;
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= S_DRAIN;
               end else begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               rsp_empty_ff <= 1'b0;
               rsp_last_ff  <= emit_ff == out_count_ff - OCW'(1);
               emit_ff      <= emit_ff + OCW'(1);
               if (emit_ff == out_count_ff - OCW'(1)) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== test/polygon_plane_clipper_checker.sv =====
// Checker for the polygon plane clipper: predicts clipped polygons and compares results.
`timescale 1ns / 100ps

module polygon_plane_clipper_checker
   import pcl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata,
   output int                   failures,
   output int                   pending,
   output int                   polygons_closed,
   output int                   empty_polygons,
   output int                   vertices_checked
);

   localparam int STORE_DEPTH = MAX_VERTS_DEF;
   localparam int OUT_DEPTH = 2 * MAX_VERTS_DEF + 2;
   localparam longint ONE = 65536;

   typedef longint triple_type [3];

   // Shadow copy of the plane registers and vertex store.
   longint     plane_normal [3];
   longint     plane_origin [3];
   longint     tolerance;
   triple_type vert_store [STORE_DEPTH];
   int         vert_count;
   triple_type clipped [OUT_DEPTH];
   int         clipped_count;
   rsp_type    expected_vertices [$];

   assign pending = expected_vertices.size();

   // One line per mismatch, and a running count.
   task automatic report_mismatch(string what);
      $display("%0t: mismatch: %s", $realtime, what);
      failures++;
   endtask

   // Fixed-point product of a normal component and a wide difference, floored.
   function automatic longint mul_q(longint n, longint d);
      longint lo;
      lo = d & 64'hFFFF;
      return n * (d >>> 16) + ((n * lo) >>> 16);
   endfunction

   function automatic longint dot_normal(triple_type d);
      return mul_q(plane_normal[0], d[0]) + mul_q(plane_normal[1], d[1]) +
             mul_q(plane_normal[2], d[2]);
   endfunction

   function automatic triple_type diff(triple_type a, triple_type b);
      triple_type r;
      for (int k = 0; k < 3; k++) r[k] = a[k] - b[k];
      return r;
   endfunction

   function automatic bit above_plane(triple_type p);
      triple_type o;
      for (int k = 0; k < 3; k++) o[k] = plane_origin[k];
      return dot_normal(diff(p, o)) > 0;
   endfunction

   function automatic bit apart(triple_type a, triple_type b);
      longint d;
      for (int k = 0; k < 3; k++) begin
         d = a[k] - b[k];
         if (d < 0) d = -d;
         if (d > tolerance) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void append_vertex(triple_type p);
      if (clipped_count < OUT_DEPTH) begin
         clipped[clipped_count] = p;
         clipped_count++;
      end
   endfunction

   // Near-duplicates of the previous vertex, and of the first on the closing edge, are dropped.
   function automatic void append_distinct(triple_type p, bit closing);
      if (clipped_count == 0 || (apart(p, clipped[clipped_count-1]) &&
                                 (!closing || apart(p, clipped[0]))))
         append_vertex(p);
   endfunction

   // Intersection of an edge with the plane, with the parameter clamped to 0..1.
   function automatic triple_type intersection(triple_type prev, triple_type cur, longint num,
                                               longint den);
      longint unsigned a, b, q;
      triple_type r, d;
      q = 0;
      d = diff(cur, prev);
      if (num == 0 || ((num < 0) != (den < 0))) return prev;
      a = (num < 0) ? -num : num;
      b = (den < 0) ? -den : den;
      if (a >= b) return cur;
      for (int i = 0; i < FRAC_W; i++) begin
         a = a << 1;
         q = q << 1;
         if (a >= b) begin
            a = a - b;
            q = q | 1;
         end
      end
      for (int k = 0; k < 3; k++) r[k] = prev[k] + ((longint'(q) * d[k]) >>> 16);
      return r;
   endfunction

   // Walk the edges, the closing one included, until a firm second crossing, and queue the expected vertices.
   function automatic void clip_polygon(int n);
      triple_type prev, cur, o, dn;
      bit prev_in, cur_in, closing;
      int crossings;
      longint den;
      rsp_type r;
      prev = vert_store[0];
      prev_in = above_plane(prev);
      crossings = 0;
      clipped_count = 0;
      for (int k = 0; k < 3; k++) o[k] = plane_origin[k];
      for (int i = 0; i <= n; i++) begin
         closing = (i == n);
         if (closing) cur = vert_store[0];
         else cur = vert_store[i];
         if (prev_in) append_distinct(prev, closing);
         cur_in = above_plane(cur);
         if (prev_in != cur_in) begin
            den = dot_normal(diff(cur, prev));
            if (den != 0) begin
               dn = diff(o, prev);
               append_distinct(intersection(prev, cur, dot_normal(dn), den), closing);
            end
            crossings++;
            if (crossings >= 2) begin
               if (den > -ONE && den < ONE) begin
                  crossings = 0;
               end else begin
                  // After a firm second crossing that ends above the plane, the rest is copied as is.
                  if (cur_in)
                     for (int j = i; j < n; j++) append_vertex(vert_store[j]);
                  break;
               end
            end
         end
         prev = cur;
         prev_in = cur_in;
      end
      polygons_closed++;
      if (clipped_count < MIN_POLY) begin
         r = '{out_x: '0, out_y: '0, out_z: '0, poly_empty: 1'b1, last_out: 1'b1};
         expected_vertices.push_back(r);
         empty_polygons++;
      end else begin
         for (int i = 0; i < clipped_count; i++) begin
            r.out_x = clipped[i][0][COORD_W-1:0];
            r.out_y = clipped[i][1][COORD_W-1:0];
            r.out_z = clipped[i][2][COORD_W-1:0];
            r.poly_empty = 1'b0;
            r.last_out = (i + 1 == clipped_count);
            expected_vertices.push_back(r);
         end
      end
   endfunction

   // Follow register writes, vertex transfers and result transfers.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            plane_normal[k] = 0;
            plane_origin[k] = 0;
         end
         plane_normal[2] = ONE;
         tolerance = 1;
         vert_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NORMAL_X: plane_normal[0] = $signed(csr_wdata);
               CSR_NORMAL_Y: plane_normal[1] = $signed(csr_wdata);
               CSR_NORMAL_Z: plane_normal[2] = $signed(csr_wdata);
               CSR_ORIGIN_X: plane_origin[0] = $signed(csr_wdata);
               CSR_ORIGIN_Y: plane_origin[1] = $signed(csr_wdata);
               CSR_ORIGIN_Z: plane_origin[2] = $signed(csr_wdata);
               CSR_DUP_TOL:  tolerance = csr_wdata[TOL_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (vert_count < STORE_DEPTH) begin
               vert_store[vert_count][0] = req_data.vert_x;
               vert_store[vert_count][1] = req_data.vert_y;
               vert_store[vert_count][2] = req_data.vert_z;
               vert_count++;
            end
            if (req_data.last_in) begin
               clip_polygon(vert_count);
               vert_count = 0;
            end
         end
         if (rsp_valid) begin
            if (expected_vertices.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", rsp_data));
            end else begin
               want = expected_vertices.pop_front();
               vertices_checked++;
               if (rsp_data.out_x !== want.out_x)
                  report_mismatch($sformatf("out_x %h, expected %h", rsp_data.out_x, want.out_x));
               if (rsp_data.out_y !== want.out_y)
                  report_mismatch($sformatf("out_y %h, expected %h", rsp_data.out_y, want.out_y));
               if (rsp_data.out_z !== want.out_z)
                  report_mismatch($sformatf("out_z %h, expected %h", rsp_data.out_z, want.out_z));
               if (rsp_data.poly_empty !== want.poly_empty)
                  report_mismatch($sformatf("poly_empty %b, expected %b", rsp_data.poly_empty,
                                            want.poly_empty));
               if (rsp_data.last_out !== want.last_out)
                  report_mismatch($sformatf("last_out %b, expected %b", rsp_data.last_out,
                                            want.last_out));
            end
         end
      end
   end

   initial begin
      failures = 0;
      polygons_closed = 0;
      empty_polygons = 0;
      vertices_checked = 0;
   end

endmodule

// ===== test/testbench.sv =====
// Top of the polygon plane clipper testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
   import pcl_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 450;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef enum int {COORD_GRID, COORD_WIDE, COORD_EXTREME} coord_mode_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_data;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COORD_W-1:0]   csr_wdata;
   int                   failures, pending, polygons_closed, empty_polygons, vertices_checked;
   int                   cycles;
   int                   burst_left;
   bit                   gaps_on;
   int                   vertices_sent;

   polygon_plane_clipper_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   polygon_plane_clipper_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .failures(failures), .pending(pending), .polygons_closed(polygons_closed),
      .empty_polygons(empty_polygons), .vertices_checked(vertices_checked)
   );

   // Free-running clock, 20 ns period.
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // One vertex transfer; when gaps are on, gaps come between bursts of random length.
   task automatic send_vertex(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [COORD_W-1:0] z, logic last);
      logic held;
      if (gaps_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      if (burst_left > 0) burst_left--;
      start <= 1'b1;
      req_data <= '{vert_x: x, vert_y: y, vert_z: z, last_in: last};
      do begin
         @(negedge clock);
         held = busy;
         @(posedge clock);
      end while (held);
      vertices_sent++;
   endtask

   // Register write over the configuration channel.
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [COORD_W-1:0] value);
      logic ready_seen;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do begin
         @(negedge clock);
         ready_seen = csr_ready;
         @(posedge clock);
      end while (!ready_seen);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Hold off until every expected vertex has come and the block has gone quiet.
   task automatic drain;
      logic quiet;
      start <= 1'b0;
      do begin
         @(negedge clock);
         quiet = (pending == 0) && !busy;
         @(posedge clock);
      end while (!quiet);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_plane(int nx, int ny, int nz, int ox, int oy, int oz, int tol);
      drain();
      write_register(CSR_NORMAL_X, nx);
      write_register(CSR_NORMAL_Y, ny);
      write_register(CSR_NORMAL_Z, nz);
      write_register(CSR_ORIGIN_X, ox);
      write_register(CSR_ORIGIN_Y, oy);
      write_register(CSR_ORIGIN_Z, oz);
      write_register(CSR_DUP_TOL, tol);
   endtask

   function automatic logic [COORD_W-1:0] pick_coord(coord_mode_type mode);
      case (mode)
         COORD_GRID:  return (int'($urandom_range(0, 8)) - 4) * 32768 + $urandom_range(0, 2);
         COORD_WIDE:  return $urandom;
         default: begin
            case ($urandom_range(0, 4))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0;
               3: return 32'h1;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   // Random polygon, mostly small, sometimes beyond the vertex store.
   task automatic send_random_polygon;
      int n;
      coord_mode_type mode;
      case ($urandom_range(0, 19))
         0: n = $urandom_range(1, 2);
         1: n = $urandom_range(16, 20);
         default: n = $urandom_range(3, 8);
      endcase
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0, 1: mode = COORD_WIDE;
            2: mode = COORD_EXTREME;
            default: mode = COORD_GRID;
         endcase
         send_vertex(pick_coord(mode), pick_coord(mode), pick_coord(mode), i == n - 1);
      end
   endtask

   initial begin
      int sent_at_phase;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cycles = 0;
      burst_left = 0;
      gaps_on = 1'b0;
      vertices_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed polygons against the reset plane z = 0.
      send_vertex(32'h0001_0000, 32'h0, 32'h0001_0000, 1'b1);
      send_vertex(32'h0, 32'h0, 32'h0001_0000, 1'b0);
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0002_0000, 1'b0);
      send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      send_vertex(32'h0, 32'h0, 32'h0001_0000, 1'b0);
      send_vertex(32'h0002_0000, 32'h0, 32'hFFFF_0000, 1'b0);
      send_vertex(32'h0, 32'h0002_0000, 32'hFFFE_0000, 1'b1);
      send_vertex(32'h0, 32'h0, 32'h0, 1'b0);
      send_vertex(32'h0001_0000, 32'h0, 32'h0, 1'b0);
      send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0, 1'b1);
      // More vertices than the store holds; the surplus is ignored.
      for (int i = 0; i < 17; i++)
         send_vertex(i * 32'h0001_0000, (i % 3) * 32'h0001_0000,
                     (i % 2) ? 32'h0001_0000 : 32'hFFFF_0000, i == 16);

      // Random phases, each under its own plane and tolerance.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_plane(65536, 0, 0, 0, 0, 0, 0);
            1: set_plane(32'h7FFF_FFFF, 32'h8000_0000, $urandom, $urandom_range(0, 65535),
                         -$urandom_range(0, 65535), 0, 65535);
            2: set_plane(int'($urandom_range(0, 262144)) - 131072,
                         int'($urandom_range(0, 262144)) - 131072,
                         int'($urandom_range(0, 262144)) - 131072,
                         int'($urandom_range(0, 65536)) - 32768, 0,
                         int'($urandom_range(0, 65536)) - 32768, $urandom_range(0, 65535));
            3: set_plane(0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1);
            4: set_plane(int'($urandom_range(0, 6)) - 3, int'($urandom_range(0, 6)) - 3,
                         $urandom_range(1, 3), 0, 0, 0, 0);
            default: begin
               set_plane($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1);
               write_register(CSR_UNUSED, $urandom);
            end
         endcase
         gaps_on = (phase % 3) != 2;
         sent_at_phase = vertices_sent;
         while (vertices_sent - sent_at_phase < RANDOM_ITEMS / 6) send_random_polygon();
      end

      drain();
      repeat (50) @(posedge clock);
      $display("Covered %0d vertices in %0d polygons, %0d of them empty, over seven planes.",
               vertices_sent, polygons_closed, empty_polygons);
      $display("Checked %0d result vertices, %0d mismatches.", vertices_checked, failures);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/pcl_pkg.sv
hw/rtl/pcl_ram.sv
hw/rtl/pcl_div.sv
hw/rtl/pcl_core.sv
hw/rtl/polygon_plane_clipper_top.sv
test/polygon_plane_clipper_checker.sv
test/testbench.sv
